// ===== rtl/stt_pkg.sv =====
// Shared types and constants for the segment table translation block.
// Used by every module in rtl/; depends on nothing else.
package stt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SEG_W  = 6;
  localparam int ADDR_W = 31;
  localparam int PA_W   = 32;
  localparam int USED_W = 7;
  localparam int RIGHTS_W = 3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_XLATE  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACC_READ  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_EXEC  = 2'd2,
    ACC_ANY   = 2'd3
  } access_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_INVALID = 3'd2,
    STS_LIMIT   = 3'd3,
    STS_PROTECT = 3'd4
  } status_e;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_LOOKUP = 1'b1
  } back_state_e;

  // Rights bit order: read, write, execute from bit 0 up.
  typedef struct packed {
    kind_e                 kind;
    logic [SEG_W-1:0]      segment;
    logic [ADDR_W-1:0]     offset;
    logic [ADDR_W-1:0]     base;
    logic [ADDR_W-1:0]     limit;
    logic [RIGHTS_W-1:0]   rights;
    access_e               access;
  } item_t;

  typedef struct packed {
    logic  empty;
    item_t item;
  } queue_head_t;

endpackage

// ===== rtl/stt_front.sv =====
// Front stage: accepts input beats, decodes them into an operation record
// and holds it until the queue takes it. Uses stt_pkg.
module stt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic [stt_pkg::SEG_W-1:0]  segment_i,
  input  logic [stt_pkg::ADDR_W-1:0] offset_i,
  input  logic [stt_pkg::ADDR_W-1:0] base_address_i,
  input  logic [stt_pkg::ADDR_W-1:0] limit_size_i,
  input  logic                     may_read_i,
  input  logic                     may_write_i,
  input  logic                     may_execute_i,
  input  logic [1:0]               access_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output stt_pkg::item_t           item_o
);

  logic           valid_q, valid_d;
  stt_pkg::item_t item_q, item_d;
  logic           load;

  assign in_stall_o = valid_q && q_full_i;
  assign push_o     = valid_q && !q_full_i;
  assign load       = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    item_d.kind    = stt_pkg::kind_e'(kind_i);
    item_d.segment = segment_i;
    item_d.offset  = offset_i;
    item_d.base    = base_address_i;
    item_d.limit   = limit_size_i;
    item_d.rights  = {may_execute_i, may_write_i, may_read_i};
    item_d.access  = stt_pkg::access_e'(access_i);
    valid_d        = load | (valid_q & q_full_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/stt_fifo.sv =====
// Short queue between the front and back stages.
// Holds decoded operation records; uses stt_pkg.
module stt_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  stt_pkg::item_t        item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output stt_pkg::queue_head_t  head_o
);

  stt_pkg::item_t                  mem_q [stt_pkg::FIFO_DEPTH];
  logic [stt_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [stt_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [stt_pkg::FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o       = (cnt_q == stt_pkg::FIFO_CNT_W'(stt_pkg::FIFO_DEPTH));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && !head_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == stt_pkg::FIFO_PTR_W'(stt_pkg::FIFO_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == stt_pkg::FIFO_PTR_W'(stt_pkg::FIFO_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
// Back stage: owns the segment table, executes add, remove, translate and no-op,
// and drives the registered result channel. Uses stt_pkg.
module stt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stt_pkg::queue_head_t        head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [stt_pkg::PA_W-1:0]    phys_addr_o,
  output logic [stt_pkg::SEG_W-1:0]   segment_index_o,
  output logic [stt_pkg::USED_W-1:0]  entries_used_o
);

  // Table storage
  logic [stt_pkg::ADDR_W-1:0]   base_q   [stt_pkg::TABLE_ENTRIES];
  logic [stt_pkg::ADDR_W-1:0]   limit_q  [stt_pkg::TABLE_ENTRIES];
  logic [stt_pkg::RIGHTS_W-1:0] rights_q [stt_pkg::TABLE_ENTRIES];
  logic [stt_pkg::CNT_W-1:0]    count_q, count_d;

  stt_pkg::back_state_e state_q, state_d;

  // Lookup registers for the translate check in the lookup state
  logic                         lk_invalid_q;
  logic [stt_pkg::ADDR_W-1:0]   lk_base_q, lk_limit_q, lk_offset_q;
  logic [stt_pkg::RIGHTS_W-1:0] lk_rights_q;
  stt_pkg::access_e             lk_access_q;

  // Output register
  logic                         out_valid_q;
  stt_pkg::status_e             status_q, status_d;
  logic [stt_pkg::PA_W-1:0]     pa_q, pa_d;
  logic [stt_pkg::SEG_W-1:0]    sidx_q, sidx_d;
  logic [stt_pkg::USED_W-1:0]   used_q;

  stt_pkg::item_t               item;
  logic [stt_pkg::USED_W-1:0]   seg_ext, cnt_ext;
  logic                         seg_bad, tbl_full, out_free, right_ok;
  logic                         res_en, wr_add, do_remove, lk_load;

  assign item     = head_i.item;
  assign seg_ext  = stt_pkg::USED_W'(item.segment);
  assign cnt_ext  = stt_pkg::USED_W'(count_q);
  assign seg_bad  = (seg_ext >= cnt_ext);
  assign tbl_full = (count_q == stt_pkg::CNT_W'(stt_pkg::TABLE_ENTRIES));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (lk_access_q)
      stt_pkg::ACC_READ:  right_ok = lk_rights_q[0];
      stt_pkg::ACC_WRITE: right_ok = lk_rights_q[1];
      stt_pkg::ACC_EXEC:  right_ok = lk_rights_q[2];
      default:            right_ok = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stt_pkg::BK_IDLE: begin
        if (!head_i.empty && out_free && item.kind == stt_pkg::KIND_XLATE) begin
          state_d = stt_pkg::BK_LOOKUP;
        end
      end
      stt_pkg::BK_LOOKUP: begin
        if (out_free) begin
          state_d = stt_pkg::BK_IDLE;
        end
      end
      default: state_d = stt_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    res_en    = 1'b0;
    wr_add    = 1'b0;
    do_remove = 1'b0;
    lk_load   = 1'b0;
    count_d   = count_q;
    status_d  = stt_pkg::STS_OK;
    pa_d      = '0;
    sidx_d    = '0;
    case (state_q)
      stt_pkg::BK_IDLE: begin
        if (!head_i.empty && out_free) begin
          pop_o = 1'b1;
          case (item.kind)
            stt_pkg::KIND_ADD: begin
              res_en = 1'b1;
              if (tbl_full) begin
                status_d = stt_pkg::STS_FULL;
              end else begin
                wr_add  = 1'b1;
                sidx_d  = stt_pkg::SEG_W'(count_q);
                count_d = count_q + 1'b1;
              end
            end
            stt_pkg::KIND_XLATE: begin
              lk_load = 1'b1;
            end
            stt_pkg::KIND_REMOVE: begin
              res_en = 1'b1;
              if (seg_bad) begin
                status_d = stt_pkg::STS_INVALID;
              end else begin
                do_remove = 1'b1;
                count_d   = count_q - 1'b1;
              end
            end
            default: begin
              res_en = 1'b1;
            end
          endcase
        end
      end
      stt_pkg::BK_LOOKUP: begin
        if (out_free) begin
          res_en = 1'b1;
          if (lk_invalid_q) begin
            status_d = stt_pkg::STS_INVALID;
          end else if (lk_offset_q >= lk_limit_q) begin
            status_d = stt_pkg::STS_LIMIT;
          end else if (!right_ok) begin
            status_d = stt_pkg::STS_PROTECT;
          end else begin
            pa_d = stt_pkg::PA_W'(lk_base_q) + stt_pkg::PA_W'(lk_offset_q);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stt_pkg::BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= res_en | (out_valid_q & out_stall_i);
    end
  end

  // Table writes: append at the fill point, or close the gap on remove
  always_ff @(posedge clk_i) begin
    if (wr_add) begin
      base_q[count_q[stt_pkg::IDX_W-1:0]]   <= item.base;
      limit_q[count_q[stt_pkg::IDX_W-1:0]]  <= item.limit;
      rights_q[count_q[stt_pkg::IDX_W-1:0]] <= item.rights;
    end
    if (do_remove) begin
      for (int i = 0; i < stt_pkg::TABLE_ENTRIES - 1; i++) begin
        if (stt_pkg::USED_W'(i) >= seg_ext && stt_pkg::USED_W'(i + 1) < cnt_ext) begin
          base_q[i]   <= base_q[i + 1];
          limit_q[i]  <= limit_q[i + 1];
          rights_q[i] <= rights_q[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_load) begin
      lk_invalid_q <= seg_bad;
      lk_base_q    <= base_q[item.segment[stt_pkg::IDX_W-1:0]];
      lk_limit_q   <= limit_q[item.segment[stt_pkg::IDX_W-1:0]];
      lk_rights_q  <= rights_q[item.segment[stt_pkg::IDX_W-1:0]];
      lk_offset_q  <= item.offset;
      lk_access_q  <= item.access;
    end
    if (res_en) begin
      status_q <= status_d;
      pa_q     <= pa_d;
      sidx_q   <= sidx_d;
      used_q   <= stt_pkg::USED_W'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign phys_addr_o     = pa_q;
  assign segment_index_o = sidx_q;
  assign entries_used_o  = used_q;

endmodule

// ===== rtl/segment_table_translation_top.sv =====
// Segment table translation top: front decode, queue and table back end.
// Each beat passes the front register, the queue and the output register; a translate also
// passes the lookup registers. Add, remove and no-op beats go at one per cycle unless the
// output stalls; a translate holds the back end for its table read, limit/rights check and add.
// Reset (rst_ni low, asynchronous) empties the table, the queue and the output register;
// table contents are not cleared and are only used below the entry count.
module segment_table_translation_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [stt_pkg::SEG_W-1:0]   segment_i,
  input  logic [stt_pkg::ADDR_W-1:0]  offset_i,
  input  logic [stt_pkg::ADDR_W-1:0]  base_address_i,
  input  logic [stt_pkg::ADDR_W-1:0]  limit_size_i,
  input  logic                        may_read_i,
  input  logic                        may_write_i,
  input  logic                        may_execute_i,
  input  logic [1:0]                  access_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [stt_pkg::PA_W-1:0]    phys_addr_o,
  output logic [stt_pkg::SEG_W-1:0]   segment_index_o,
  output logic [stt_pkg::USED_W-1:0]  entries_used_o
);

  // Front to queue
  logic                 push;
  logic                 q_full;
  stt_pkg::item_t       front_item;
  // Queue to back
  stt_pkg::queue_head_t head;
  logic                 pop;

  // Register and decode each request beat; hold it while the queue is full.
  stt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .segment_i      (segment_i),
    .offset_i       (offset_i),
    .base_address_i (base_address_i),
    .limit_size_i   (limit_size_i),
    .may_read_i     (may_read_i),
    .may_write_i    (may_write_i),
    .may_execute_i  (may_execute_i),
    .access_i       (access_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (front_item)
  );

  // Decouple the front from the back so either side can stall on its own.
  stt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // Execute operations in order against the table; results leave through
  // a single output register that advances whenever the sink takes a beat.
  stt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .phys_addr_o     (phys_addr_o),
    .segment_index_o (segment_index_o),
    .entries_used_o  (entries_used_o)
  );

endmodule
